// ===== sv/prcm_pkg.sv =====
// shared types, register indexes and color table for the phase rotate colormap
package prcm_pkg;

  localparam int SampleW = 24;
  localparam int PhaseW  = 18;
  localparam int GainW   = 32;
  localparam int ChanW   = 8;
  localparam int FracW   = 21;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam logic [1:0] REG_PHASE_COS = 2'd0;
  localparam logic [1:0] REG_PHASE_SIN = 2'd1;
  localparam logic [1:0] REG_NORM_GAIN = 2'd2;

  localparam logic signed [PhaseW-1:0] PHASE_COS_RST = 18'sh10000;
  localparam logic signed [PhaseW-1:0] PHASE_SIN_RST = 18'sh00000;
  localparam logic [GainW-1:0]         NORM_GAIN_RST = 32'h0100_0000;

  // plus and minus one in the normalized q23 domain
  localparam logic signed [35:0] ONE_Q23     = 36'sh000800000;
  localparam logic signed [35:0] NEG_ONE_Q23 = -36'sh000800000;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic signed [ChanW:0] red;
    logic signed [ChanW:0] green;
    logic signed [ChanW:0] blue;
  } slope_t;

  function automatic rgb_t pal_color(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'h00, 8'h00, 8'h90};
      4'd1:    c = '{8'h00, 8'h0f, 8'hff};
      4'd2:    c = '{8'h00, 8'h90, 8'hff};
      4'd3:    c = '{8'h0f, 8'hff, 8'hee};
      4'd4:    c = '{8'hff, 8'hff, 8'hff};
      4'd5:    c = '{8'hff, 8'hee, 8'h00};
      4'd6:    c = '{8'hff, 8'h70, 8'h00};
      4'd7:    c = '{8'hee, 8'h00, 8'h00};
      4'd8:    c = '{8'h7f, 8'h00, 8'h00};
      default: c = '{8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

endpackage

// ===== sv/prcm_if.sv =====
// sample and pixel stream interfaces
interface prcm_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [prcm_pkg::SampleW-1:0] sample_re;
  logic signed [prcm_pkg::SampleW-1:0] sample_im;

  modport source (output valid, sample_re, sample_im, input ready);
  modport sink   (input valid, sample_re, sample_im, output ready);
endinterface

interface prcm_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [prcm_pkg::ChanW-1:0]   red;
  logic [prcm_pkg::ChanW-1:0]   green;
  logic [prcm_pkg::ChanW-1:0]   blue;
  logic                         out_of_range;

  modport source (output valid, red, green, blue, out_of_range, input ready);
  modport sink   (input valid, red, green, blue, out_of_range, output ready);
endinterface

// ===== sv/phase_rotate_colormap_pixel.sv =====
// phase rotate colormap pixel: six stage pipeline from complex sample to rgb pixel
// throughput: one pixel per cycle while pixel_out.ready is high
// each stage advances when its successor is empty or moving
// the output register stage lets new samples enter while a pixel waits, until all stages fill
// reset clears all valid bits and loads phase_cos 65536, phase_sin 0, norm_gain 2^24
module phase_rotate_colormap_pixel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prcm_pkg::AddrW-1:0]    paddr,
  input  logic [prcm_pkg::DataW-1:0]    pwdata,
  output logic [prcm_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  prcm_sample_if.sink                   sample_in,
  prcm_pixel_if.source                  pixel_out
);

  logic signed [prcm_pkg::PhaseW-1:0] phase_cos;
  logic signed [prcm_pkg::PhaseW-1:0] phase_sin;
  logic [prcm_pkg::GainW-1:0]         norm_gain;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_cos <= prcm_pkg::PHASE_COS_RST;
      phase_sin <= prcm_pkg::PHASE_SIN_RST;
      norm_gain <= prcm_pkg::NORM_GAIN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        prcm_pkg::REG_PHASE_COS: phase_cos <= pwdata[prcm_pkg::PhaseW-1:0];
        prcm_pkg::REG_PHASE_SIN: phase_sin <= pwdata[prcm_pkg::PhaseW-1:0];
        prcm_pkg::REG_NORM_GAIN: norm_gain <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      prcm_pkg::REG_PHASE_COS: prdata = {14'd0, phase_cos};
      prcm_pkg::REG_PHASE_SIN: prdata = {14'd0, phase_sin};
      prcm_pkg::REG_NORM_GAIN: prdata = norm_gain;
      default:                 prdata = '0;
    endcase
  end

  // stage valids and advance enables
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || pixel_out.ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign sample_in.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= sample_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // stage 1: rotation products
  logic signed [41:0] prod_c;
  logic signed [41:0] prod_s;

  always_ff @(posedge clk) begin
    if (en1) begin
      prod_c <= phase_cos * sample_in.sample_re;
      prod_s <= phase_sin * sample_in.sample_im;
    end
  end

  // stage 2: real part with floor shift
  logic signed [42:0] rot_diff;
  logic signed [26:0] p;

  assign rot_diff = 43'(prod_c) - 43'(prod_s);

  always_ff @(posedge clk) begin
    if (en2) begin
      p <= rot_diff[42:16];
    end
  end

  // stage 3: normalization product
  logic signed [32:0] gain_s;
  logic signed [59:0] prod_g;

  assign gain_s = $signed({1'b0, norm_gain});

  always_ff @(posedge clk) begin
    if (en3) begin
      prod_g <= p * gain_s;
    end
  end

  // stage 4: range check, segment select, table lookup
  logic signed [35:0] xq;
  logic signed [35:0] n_full;
  logic               oor_next;
  logic [3:0]         seg_next;
  logic [3:0]         seg_hi;
  prcm_pkg::rgb_t     c0_next;
  prcm_pkg::rgb_t     c1_next;
  prcm_pkg::rgb_t     c0;
  prcm_pkg::slope_t   slope;
  logic [prcm_pkg::FracW-1:0] frac;
  logic               oor4;
  logic [3:0]         seg4;

  assign xq       = prod_g[59:24];
  assign oor_next = (xq < prcm_pkg::NEG_ONE_Q23) || (xq > prcm_pkg::ONE_Q23);
  assign n_full   = xq + prcm_pkg::ONE_Q23;
  assign seg_next = n_full[24:21];
  assign seg_hi   = (seg_next == 4'd8) ? 4'd8 : seg_next + 4'd1;
  assign c0_next  = oor_next ? '0 : prcm_pkg::pal_color(seg_next);
  assign c1_next  = oor_next ? '0 : prcm_pkg::pal_color(seg_hi);

  always_ff @(posedge clk) begin
    if (en4) begin
      oor4        <= oor_next;
      seg4        <= seg_next;
      c0          <= c0_next;
      frac        <= n_full[prcm_pkg::FracW-1:0];
      slope.red   <= $signed({1'b0, c1_next.red})   - $signed({1'b0, c0_next.red});
      slope.green <= $signed({1'b0, c1_next.green}) - $signed({1'b0, c0_next.green});
      slope.blue  <= $signed({1'b0, c1_next.blue})  - $signed({1'b0, c0_next.blue});
    end
  end

  // stage 5: interpolation products
  logic signed [21:0] frac_s;
  logic signed [30:0] ip_r, ip_g, ip_b;
  prcm_pkg::rgb_t     c0_5;
  logic               oor5;

  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (en5) begin
      ip_r <= slope.red   * frac_s;
      ip_g <= slope.green * frac_s;
      ip_b <= slope.blue  * frac_s;
      c0_5 <= c0;
      oor5 <= oor4;
    end
  end

  // stage 6: floor shift and add into the output register
  logic signed [9:0] sum_r, sum_g, sum_b;

  assign sum_r = $signed({2'b00, c0_5.red})   + ip_r[30:21];
  assign sum_g = $signed({2'b00, c0_5.green}) + ip_g[30:21];
  assign sum_b = $signed({2'b00, c0_5.blue})  + ip_b[30:21];

  always_ff @(posedge clk) begin
    if (en6) begin
      pixel_out.red          <= sum_r[7:0];
      pixel_out.green        <= sum_g[7:0];
      pixel_out.blue         <= sum_b[7:0];
      pixel_out.out_of_range <= oor5;
    end
  end

  assign pixel_out.valid = v6;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !sample_in.ready |-> (v1 && v2 && v3 && v4 && v5 && v6))
    else $error("input blocked with a bubble in the pipeline");

  a_seg_in_table: assert property (@(posedge clk) disable iff (rst)
    (v4 && !oor4) |-> (seg4 <= 4'd8))
    else $error("segment beyond color table");

  a_oor_black_stage: assert property (@(posedge clk) disable iff (rst)
    (v4 && oor4) |-> (c0 == '0 && slope == '0))
    else $error("out of range item carries color");

  a_oor_black_out: assert property (@(posedge clk) disable iff (rst)
    (pixel_out.valid && pixel_out.out_of_range) |->
      (pixel_out.red == '0 && pixel_out.green == '0 && pixel_out.blue == '0))
    else $error("out of range pixel not black");

endmodule

// ===== tb/phase_rotate_colormap_pixel_tb.sv =====
// testbench for the phase rotate colormap pixel mapper: apb setup, sample streams, pixel scoreboard
`timescale 1ns / 100ps
module phase_rotate_colormap_pixel_tb;

  localparam int StallLimit = 2000;
  localparam int MaxShown = 10;
  localparam longint OneQ23 = 64'sd8388608;
  localparam longint FracOne = 64'sd2097152;
  // nine colors, entry 0 in the low bits, each 24 bits as red green blue
  localparam logic [9*24-1:0] ColorTable = {
    24'h7f0000, 24'hee0000, 24'hff7000, 24'hffee00, 24'hffffff,
    24'h0fffee, 24'h0090ff, 24'h000fff, 24'h000090};

  typedef struct packed {
    logic [prcm_pkg::ChanW-1:0] red;
    logic [prcm_pkg::ChanW-1:0] green;
    logic [prcm_pkg::ChanW-1:0] blue;
    logic                       out_of_range;
  } pixel_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [prcm_pkg::AddrW-1:0] paddr;
  logic [prcm_pkg::DataW-1:0] pwdata;
  logic [prcm_pkg::DataW-1:0] prdata;
  logic                       pready;

  prcm_sample_if smp();
  prcm_pixel_if  pix();

  phase_rotate_colormap_pixel dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sample_in (smp),
    .pixel_out (pix)
  );

  logic signed [prcm_pkg::PhaseW-1:0] cur_cos;
  logic signed [prcm_pkg::PhaseW-1:0] cur_sin;
  logic [prcm_pkg::GainW-1:0]         cur_gain;
  pixel_t                             pixel_queue[$];
  int                                 mismatch_cnt = 0;
  int                                 stall_cnt = 0;
  logic                               idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [prcm_pkg::ChanW-1:0] blend(input int seg, input int sh,
                                                       input longint frac);
    longint c0;
    longint c1;
    c0 = longint'(ColorTable[seg*24 + sh +: 8]);
    c1 = longint'(ColorTable[(seg+1)*24 + sh +: 8]);
    return prcm_pkg::ChanW'(c0 + (((c1 - c0) * frac) >>> prcm_pkg::FracW));
  endfunction

  function automatic pixel_t map_sample(input logic signed [prcm_pkg::SampleW-1:0] re,
                                        input logic signed [prcm_pkg::SampleW-1:0] im);
    longint proj;
    longint xq;
    longint n;
    longint seg;
    longint frac;
    pixel_t px;
    proj = (longint'(cur_cos) * longint'(re) - longint'(cur_sin) * longint'(im)) >>> 16;
    xq = (proj * longint'(cur_gain)) >>> 24;
    px = '0;
    if (xq < -OneQ23 || xq > OneQ23) begin
      px.out_of_range = 1'b1;
    end else begin
      n = xq + OneQ23;
      seg = n >>> prcm_pkg::FracW;
      frac = n & (FracOne - 1);
      // plus one lands on the far end of the last segment
      if (seg >= 8) begin
        seg = 7;
        frac = FracOne;
      end
      px.red = blend(int'(seg), 16, frac);
      px.green = blend(int'(seg), 8, frac);
      px.blue = blend(int'(seg), 0, frac);
    end
    return px;
  endfunction

  function automatic logic signed [prcm_pkg::SampleW-1:0] rand_sample();
    logic signed [prcm_pkg::SampleW-1:0] v;
    v = prcm_pkg::SampleW'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3: v = $urandom_range(0, 1) ? {1'b0, {(prcm_pkg::SampleW-1){1'b1}}}
                                  : {1'b1, {(prcm_pkg::SampleW-1){1'b0}}};
      default: v = v >>> $urandom_range(0, prcm_pkg::SampleW-1);
    endcase
    return v;
  endfunction

  function automatic logic signed [prcm_pkg::PhaseW-1:0] rand_phase();
    if ($urandom_range(0, 7) == 0)
      return prcm_pkg::PhaseW'($urandom);
    return prcm_pkg::PhaseW'(int'($urandom_range(0, 131072)) - 65536);
  endfunction

  function automatic logic [prcm_pkg::GainW-1:0] rand_gain();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [prcm_pkg::DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic drain_pixels();
    smp.valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic signed [prcm_pkg::PhaseW-1:0] cos_v,
                            input logic signed [prcm_pkg::PhaseW-1:0] sin_v,
                            input logic [prcm_pkg::GainW-1:0]         gain_v);
    drain_pixels();
    write_reg(prcm_pkg::REG_PHASE_COS, prcm_pkg::DataW'(cos_v));
    write_reg(prcm_pkg::REG_PHASE_SIN, prcm_pkg::DataW'(sin_v));
    write_reg(prcm_pkg::REG_NORM_GAIN, gain_v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_cos = cos_v;
    cur_sin = sin_v;
    cur_gain = gain_v;
  endtask

  task automatic send_sample(input logic signed [prcm_pkg::SampleW-1:0] re,
                             input logic signed [prcm_pkg::SampleW-1:0] im);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample_re <= re;
    smp.sample_im <= im;
    do @(posedge clk); while (!smp.ready);
    pixel_queue.push_back(map_sample(re, im));
  endtask

  task automatic stream_random(input int count);
    repeat (count) send_sample(rand_sample(), rand_sample());
  endtask

  task automatic test_reset_defaults();
    send_sample(24'sh7fffff, 24'sh000000);
    send_sample(24'sh800000, 24'sh7fffff);
    send_sample(24'sh000000, 24'sh800000);
    send_sample(-24'sd1, 24'sh000000);
    send_sample(24'sd1, -24'sd1);
  endtask

  task automatic test_unit_bounds();
    set_config(18'sh10000, 18'sh00000, 32'h0200_0000);
    send_sample(24'sd4194304, 24'sd0);
    send_sample(24'sd4194305, 24'sd0);
    send_sample(-24'sd4194304, 24'sd0);
    send_sample(-24'sd4194305, 24'sd0);
    for (int k = 1; k < 8; k++)
      send_sample(prcm_pkg::SampleW'(k * 1048576 - 4194304), prcm_pkg::SampleW'($urandom));
    // just past the last knot, red slope is negative
    send_sample(24'sd3145729, 24'sd0);
  endtask

  task automatic test_sine_path();
    set_config(18'sh00000, -18'sh10000, 32'h0100_0000);
    send_sample(24'sh7fffff, 24'sh7fffff);
    send_sample(24'sh800000, 24'sh800000);
    send_sample(24'sh123456, 24'sh000000);
    set_config(18'sh10000, 18'sh10000, 32'h0100_0000);
    send_sample(24'sh7fffff, 24'sh800000);
    send_sample(24'sh800000, 24'sh7fffff);
  endtask

  task automatic test_register_extremes();
    set_config(18'sh10000, 18'sh00000, 32'h0000_0000);
    stream_random(60);
    set_config(-18'sh10000, 18'sh00000, 32'hffff_ffff);
    stream_random(60);
    set_config(18'sh1ffff, 18'sh20000, 32'h0100_0000);
    stream_random(60);
    set_config(18'sh00000, 18'sh10000, 32'h0080_0000);
    stream_random(60);
    set_config(-18'sh10000, -18'sh10000, 32'h0000_0001);
    stream_random(60);
  endtask

  task automatic test_random_phases();
    repeat (5) begin
      set_config(rand_phase(), rand_phase(), rand_gain());
      stream_random(80);
    end
  endtask

  task automatic test_steady_stream();
    set_config(rand_phase(), rand_phase(), rand_gain());
    idle_on = 1'b0;
    stream_random(100);
  endtask

  initial begin
    pix.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        pix.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        pix.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_pixel
    pixel_t got;
    pixel_t want;
    if (!rst && pix.valid && pix.ready) begin
      got = {pix.red, pix.green, pix.blue, pix.out_of_range};
      if (pixel_queue.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxShown)
          $display("unexpected pixel beat: rgb %h %h %h oor %b",
                   got.red, got.green, got.blue, got.out_of_range);
      end else begin
        want = pixel_queue.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxShown)
            $display("pixel mismatch: expected rgb %h %h %h oor %b, got rgb %h %h %h oor %b",
                     want.red, want.green, want.blue, want.out_of_range,
                     got.red, got.green, got.blue, got.out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (smp.valid && smp.ready) || (pix.valid && pix.ready) || psel)
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("FAIL phase_rotate_colormap_pixel");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    smp.valid <= 1'b0;
    smp.sample_re <= '0;
    smp.sample_im <= '0;
    cur_cos = prcm_pkg::PHASE_COS_RST;
    cur_sin = prcm_pkg::PHASE_SIN_RST;
    cur_gain = prcm_pkg::NORM_GAIN_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_unit_bounds();
    test_sine_path();
    test_register_extremes();
    test_random_phases();
    test_steady_stream();
    drain_pixels();
    if (mismatch_cnt == 0 && pixel_queue.size() == 0)
      $display("PASS phase_rotate_colormap_pixel");
    else
      $display("FAIL phase_rotate_colormap_pixel");
    $finish;
  end

endmodule
